[rtl/core/msq_pkg.sv]
package msq_pkg;

  localparam int RING_DEPTH = 256;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  localparam logic ST_DONE     = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [63:0] decode_ts;
    logic [31:0]        sample_duration;
    logic [23:0]        data_length;
    logic               is_key;
    logic [31:0]        timing_dur_us;
    logic signed [63:0] pts_us;
    logic [8:0]         pop_count;
  } msq_req_t;

  typedef struct packed {
    logic               status;
    logic [7:0]         first_slot;
    logic signed [63:0] batch_start_ts;
    logic signed [63:0] batch_end_ts;
    logic [47:0]        batch_duration;
    logic [31:0]        batch_size;
    logic [8:0]         batch_count;
    logic               batch_independent;
    logic [47:0]        batch_timing_us;
    logic signed [63:0] batch_highest_pts;
  } msq_rsp_t;

  // one stored descriptor
  typedef struct packed {
    logic signed [63:0] dts;
    logic [31:0]        dur;
    logic [23:0]        len;
    logic               key;
    logic [31:0]        tim;
    logic signed [63:0] pts;
  } msq_entry_t;

  // ring port control
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
  } msq_ram_ctl_t;

endpackage

[rtl/core/msq_ring.sv]
module msq_ring
  import msq_pkg::*;
(
  input  logic         clk,
  input  msq_ram_ctl_t ctl,
  input  msq_entry_t   wdata,
  output msq_entry_t   rdata
);

  msq_entry_t mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
    rdata <= mem[ctl.raddr];
  end

endmodule

[rtl/core/msq_accum.sv]
// Shared accumulate/compare unit: one entry folded in per cycle while en is high.
module msq_accum
  import msq_pkg::*;
(
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  msq_entry_t         ent,
  output logic signed [63:0] acc_end,
  output logic [47:0]        acc_dur,
  output logic [31:0]        acc_sz,
  output logic [47:0]        acc_tim,
  output logic signed [63:0] acc_hi
);

  logic first;

  always_ff @(posedge clk) begin
    if (clr) begin
      first   <= 1'b1;
      acc_dur <= '0;
      acc_sz  <= '0;
      acc_tim <= '0;
      acc_end <= '0;
      acc_hi  <= '0;
    end else if (en) begin
      first   <= 1'b0;
      acc_end <= ent.dts + 64'(ent.dur);
      acc_dur <= acc_dur + 48'(ent.dur);
      acc_sz  <= acc_sz + 32'(ent.len);
      acc_tim <= acc_tim + 48'(ent.tim);
      if (first || (ent.pts > acc_hi)) begin
        acc_hi <= ent.pts;
      end
    end
  end

endmodule

[rtl/core/media_sample_queue_with_totals_core.sv]
// Sample descriptor ring with running queue totals; one fold unit, one ring read port.
// Append, rejected request, pop of the whole queue: result and done come from S_FIN, the
// state after acceptance; new requests wait for idle. Receiver cannot stall.
// Pop leaving entries: S_FIN, S_WALK folds the popped entries, S_EMIT raises done, then
// S_HEAD reads the new front; S_SCAN rescans the rest when the batch held the highest pts.
// Synchronous reset clears pointers and totals; ring contents stay undefined.
module media_sample_queue_with_totals_core
  import msq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  msq_req_t req,
  output logic     busy,
  output logic     done,
  output msq_rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIN   = 3'd1; // append / reject / full pop result
  localparam logic [2:0] S_WALK  = 3'd2; // fold popped entries
  localparam logic [2:0] S_EMIT  = 3'd3; // report batch, update totals
  localparam logic [2:0] S_HEAD  = 3'd4; // read new front
  localparam logic [2:0] S_SCAN  = 3'd5; // rescan remaining for highest pts
  localparam logic [2:0] S_SDONE = 3'd6;

  logic [2:0] state;
  msq_req_t   r;
  logic       rej;

  logic [SLOT_W-1:0] head_slot;
  logic [CNT_W-1:0]  entry_count;
  logic signed [63:0] q_start, q_end, q_hi;
  logic [47:0] q_dur, q_tim;
  logic [31:0] q_sz;
  logic        q_ind;

  // walk control: issue counter, and delayed valid for registered read
  logic [CNT_W-1:0] issue;
  logic [CNT_W-1:0] left;
  logic             rd_v;
  logic             walk_is_scan;

  msq_ram_ctl_t ctl;
  msq_entry_t   wdata, rdata;
  msq_entry_t   first_ent;
  logic         first_got;

  logic clr, acc_en;
  logic signed [63:0] a_end, a_hi;
  logic [47:0] a_dur, a_tim;
  logic [31:0] a_sz;

  msq_ring u_ring (.clk(clk), .ctl(ctl), .wdata(wdata), .rdata(rdata));

  msq_accum u_acc (
    .clk(clk), .clr(clr), .en(acc_en), .ent(rdata),
    .acc_end(a_end), .acc_dur(a_dur), .acc_sz(a_sz), .acc_tim(a_tim), .acc_hi(a_hi)
  );

  logic [SLOT_W-1:0] tail_slot;
  assign tail_slot = head_slot + SLOT_W'(entry_count);

  always_comb begin
    wdata.dts = r.decode_ts;
    wdata.dur = r.sample_duration;
    wdata.len = r.data_length;
    wdata.key = r.is_key;
    wdata.tim = r.timing_dur_us;
    wdata.pts = r.pts_us;
    ctl.we    = (state == S_FIN) && !rej && (r.req_type == REQ_APPEND);
    ctl.waddr = tail_slot;
    ctl.raddr = head_slot + SLOT_W'(issue);
  end

  assign busy   = (state != S_IDLE);
  // cleared before a walk and again before the rescan of the remaining entries
  assign clr    = (state == S_IDLE) || (state == S_HEAD);
  assign acc_en = rd_v && (state == S_WALK || state == S_SCAN || state == S_SDONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_slot   <= '0;
      entry_count <= '0;
      q_start <= '0; q_end <= '0; q_hi <= '0;
      q_dur <= '0; q_tim <= '0; q_sz <= '0; q_ind <= 1'b0;
      done  <= 1'b0;
      rd_v  <= 1'b0;
      issue <= '0;
      left  <= '0;
      rej   <= 1'b0;
      walk_is_scan <= 1'b0;
      first_got <= 1'b0;
    end else begin
      done <= 1'b0;
      rd_v <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            r     <= req;
            issue <= '0;
            first_got <= 1'b0;
            if (req.req_type == REQ_APPEND) begin
              rej <= (entry_count == CNT_W'(RING_DEPTH));
            end else begin
              rej <= (req.pop_count == '0) || (CNT_W'(req.pop_count) > entry_count);
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (rej) begin
            rsp   <= '{status: ST_REJECTED, default: '0};
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (r.req_type == REQ_APPEND) begin
            rsp.status     <= ST_DONE;
            rsp.first_slot <= 8'(tail_slot);
            rsp.batch_start_ts <= (entry_count == '0) ? r.decode_ts : q_start;
            rsp.batch_end_ts   <= r.decode_ts + 64'(r.sample_duration);
            rsp.batch_duration <= q_dur + 48'(r.sample_duration);
            rsp.batch_size     <= q_sz + 32'(r.data_length);
            rsp.batch_count    <= 9'(entry_count + 1'b1);
            rsp.batch_independent <= (entry_count == '0) ? r.is_key : q_ind;
            rsp.batch_timing_us <= q_tim + 48'(r.timing_dur_us);
            if (entry_count == '0) begin
              q_start <= r.decode_ts;
              q_ind   <= r.is_key;
              q_hi    <= r.pts_us;
              rsp.batch_highest_pts <= r.pts_us;
            end else if (r.pts_us > q_hi) begin
              q_hi <= r.pts_us;
              rsp.batch_highest_pts <= r.pts_us;
            end else begin
              rsp.batch_highest_pts <= q_hi;
            end
            q_end <= r.decode_ts + 64'(r.sample_duration);
            q_dur <= q_dur + 48'(r.sample_duration);
            q_sz  <= q_sz + 32'(r.data_length);
            q_tim <= q_tim + 48'(r.timing_dur_us);
            entry_count <= entry_count + 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (CNT_W'(r.pop_count) == entry_count) begin
            rsp.status <= ST_DONE;
            rsp.first_slot <= 8'(head_slot);
            rsp.batch_start_ts <= q_start;
            rsp.batch_end_ts <= q_end;
            rsp.batch_duration <= q_dur;
            rsp.batch_size <= q_sz;
            rsp.batch_count <= 9'(entry_count);
            rsp.batch_independent <= q_ind;
            rsp.batch_timing_us <= q_tim;
            rsp.batch_highest_pts <= q_hi;
            head_slot <= head_slot + SLOT_W'(entry_count);
            entry_count <= '0;
            q_start <= '0; q_end <= '0; q_hi <= '0;
            q_dur <= '0; q_tim <= '0; q_sz <= '0; q_ind <= 1'b0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            left  <= CNT_W'(r.pop_count);
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // issue reads; accumulator folds each entry in the cycle after its read is issued
          if (left != '0) begin
            rd_v  <= 1'b1;
            issue <= issue + 1'b1;
            left  <= left - 1'b1;
          end else if (!rd_v) begin
            state <= S_EMIT;
          end
          if (rd_v && !first_got) begin
            first_ent <= rdata;
            first_got <= 1'b1;
          end
        end
        S_EMIT: begin
          rsp.status <= ST_DONE;
          rsp.first_slot <= 8'(head_slot);
          rsp.batch_start_ts <= first_ent.dts;
          rsp.batch_end_ts <= a_end;
          rsp.batch_duration <= a_dur;
          rsp.batch_size <= a_sz;
          rsp.batch_count <= r.pop_count;
          rsp.batch_independent <= first_ent.key;
          rsp.batch_timing_us <= a_tim;
          rsp.batch_highest_pts <= a_hi;
          done <= 1'b1;
          walk_is_scan <= (a_hi >= q_hi);
          head_slot <= head_slot + SLOT_W'(r.pop_count);
          entry_count <= entry_count - CNT_W'(r.pop_count);
          q_dur <= q_dur - a_dur;
          q_sz  <= q_sz - a_sz;
          q_tim <= q_tim - a_tim;
          issue <= '0;
          state <= S_HEAD;
        end
        S_HEAD: begin
          // read of new front issued here (issue = 0)
          rd_v  <= 1'b1;
          issue <= issue + 1'b1;
          left  <= entry_count - 1'b1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_v && issue == CNT_W'(1) && !walk_is_scan) begin
            // front captured below; no rescan needed
            state <= S_IDLE;
          end else if (left != '0 && walk_is_scan) begin
            rd_v  <= 1'b1;
            issue <= issue + 1'b1;
            left  <= left - 1'b1;
          end else if (!rd_v) begin
            state <= S_SDONE;
          end
          if (rd_v && issue == CNT_W'(1)) begin
            q_start <= rdata.dts;
            q_ind   <= rdata.key;
          end
        end
        S_SDONE: begin
          q_hi  <= a_hi;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the accumulator must be cleared between requests (first-fold flag)
  // so a fresh walk always starts clean
  assert property (@(posedge clk) disable iff (rst)
    done |=> !done || $past(state) == S_IDLE)
    else $error("two results back to back");
  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(RING_DEPTH))
    else $error("entry count above ring depth");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");
  assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_REJECTED) |=> $stable(entry_count))
    else $error("rejected request changed the count");

endmodule
